// ===== hdl/sonco_pkg.sv =====
// ----------------------------------------------------------------------------
// sonco_pkg
// Shared constants, types and the sine table generator for the sine NCO.
// ----------------------------------------------------------------------------
package sonco_pkg;

   // Phase accumulator width, table address width, table sample width
   localparam int PHASE_BITS      = 32;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;

   localparam int FREQ_BITS  = 24;
   localparam int OUT_BITS   = 16;
   localparam int CSR_BITS   = 32;
   localparam int CSR_IDX_W  = 2;

   localparam int QSIZE      = 1 << TABLE_ADDR_BITS;
   localparam int ENTRY_BITS = SAMPLE_BITS - 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_PHASE = 2'd2;

   // Register reset values
   localparam logic [31:0] PHASE_STEP_RST  = 32'd350;
   localparam logic [15:0] AMPLITUDE_RST   = 16'd32768;
   localparam logic [15:0] START_PHASE_RST = 16'd0;

   typedef logic [ENTRY_BITS-1:0]      entry_type;
   typedef logic [PHASE_BITS-1:0]      phase_type;
   typedef logic [TABLE_ADDR_BITS:0]   rom_addr_type;
   typedef logic signed [FREQ_BITS-1:0] freq_type;
   typedef logic signed [OUT_BITS-1:0]  sample_type;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint          ONE_Q30     = 64'sd1 << 30;
   localparam longint          FULL_SCALE  = (64'sd1 << (SAMPLE_BITS - 1)) - 64'sd1;

   // Taylor term divisors, (2n)(2n+1) for n = 1..12
   localparam longint unsigned TAYLOR_DIV [1:12] = '{
      64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   // One quarter-wave table entry: Taylor series of sin(pi/2 * k / QSIZE), Q2.30,
   // truncating steps, clamped and scaled to full scale with rounding.
   function automatic entry_type sine_entry(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint          s;
      longint          e;
      x  = (PI_HALF_Q30 * longint'(k)) >> TABLE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
         t  = ((t * x2) >> 30) / TAYLOR_DIV[n];
         if ((n % 2) == 1) begin
            s = s - longint'(t);
         end else begin
            s = s + longint'(t);
         end
      end
      if (s < 0) s = 0;
      if (s > ONE_Q30) s = ONE_Q30;
      e = (s * FULL_SCALE + (ONE_Q30 / 2)) >>> 30;
      if (e > FULL_SCALE) e = FULL_SCALE;
      return entry_type'(e);
   endfunction

endpackage

// ===== hdl/sonco_ifs.sv =====
// ----------------------------------------------------------------------------
// sonco stream interfaces
// Valid/ready channels for frequency requests and sample responses.
// ----------------------------------------------------------------------------
interface sonco_req_if;
   logic                 valid;
   logic                 ready;
   sonco_pkg::freq_type  frequency;

   modport source (output valid, output frequency, input ready);
   modport sink   (input valid, input frequency, output ready);
endinterface

interface sonco_rsp_if;
   logic                  valid;
   logic                  ready;
   sonco_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/sine_oscillator_nco_unit.sv =====
// ----------------------------------------------------------------------------
// sine_oscillator_nco_unit
// Frequency-modulated sine NCO with quarter-wave table and gain.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries one signed frequency word per sample; rsp returns one
//    signed Q1.15 sample word per request, in order.
//  - Each request reads the sine of the current phase, then the phase
//    advances by frequency * phase_step_per_unit, modulo one cycle.
//  - Throughput: one word per cycle while rsp does not stall. The
//    edge that takes the request loads the table read register; then
//    the gain/saturate output register is loaded, which drives rsp.valid
//    and the sample word.
//  - The phase update is one 32x32 truncated multiply and one add, so a
//    new word can follow every cycle while rsp does not stall.
//  - csr_*: write-only registers, written when csr_wr_en is high. Any
//    write to a known index reloads the phase from start_phase; unknown
//    indexes are ignored. Write only while the block is idle.
//  - Reset (synchronous, active high) restores the register defaults and
//    loads the phase from the default start phase; pipeline is emptied.
//  - When rsp stalls, the output register holds its word; if the table
//    stage is empty, one more request is taken into it, then req.ready drops.
// ----------------------------------------------------------------------------
module sine_oscillator_nco_unit (
   input  logic                               clock,
   input  logic                               reset,
   sonco_req_if.sink                          req,
   sonco_rsp_if.source                        rsp,
   input  logic                               csr_wr_en,
   input  logic [sonco_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sonco_pkg::CSR_BITS-1:0]     csr_wdata
);

   localparam int PB = sonco_pkg::PHASE_BITS;
   localparam int AB = sonco_pkg::TABLE_ADDR_BITS;
   localparam int SB = sonco_pkg::SAMPLE_BITS;
   localparam int EB = sonco_pkg::ENTRY_BITS;
   localparam int MAG_W = EB + 16;
   localparam int RND_W = MAG_W - (SB - 1) + 1;

   // ---------------- configuration registers ----------------
   logic [31:0] step_ff;
   logic [15:0] amp_ff;
   logic [15:0] start_ff;
   logic [15:0] start_in;
   logic        csr_hit;

   assign csr_hit = csr_wr_en && ((csr_index == sonco_pkg::REG_PHASE_STEP) ||
                                  (csr_index == sonco_pkg::REG_AMPLITUDE) ||
                                  (csr_index == sonco_pkg::REG_START_PHASE));

   // start phase as it stands after this write, for the reload
   assign start_in = (csr_wr_en && (csr_index == sonco_pkg::REG_START_PHASE)) ?
                     csr_wdata[15:0] : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= sonco_pkg::PHASE_STEP_RST;
         amp_ff   <= sonco_pkg::AMPLITUDE_RST;
         start_ff <= sonco_pkg::START_PHASE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            sonco_pkg::REG_PHASE_STEP:  step_ff  <= csr_wdata[31:0];
            sonco_pkg::REG_AMPLITUDE:   amp_ff   <= csr_wdata[15:0];
            sonco_pkg::REG_START_PHASE: start_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline handshake ----------------
   logic s1_vld_ff;
   logic out_vld_ff;
   logic out_en;
   logic s1_en;
   logic req_take;

   assign out_en    = !out_vld_ff || rsp.ready;
   assign s1_en     = !s1_vld_ff || out_en;
   assign req.ready = s1_en;
   assign req_take  = req.valid && s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_vld_ff  <= req.valid;
         if (out_en) out_vld_ff <= s1_vld_ff;
      end
   end

   // ---------------- phase accumulator ----------------
   sonco_pkg::phase_type phase_ff;
   sonco_pkg::phase_type phase_in;
   sonco_pkg::phase_type phase_load;
   sonco_pkg::phase_type phase_rst;
   sonco_pkg::phase_type phase_delta;
   logic [31:0]          freq_ext;
   logic [31:0]          step_prod;

   assign phase_load = sonco_pkg::phase_type'(start_in) << (PB - 16);
   assign phase_rst  = sonco_pkg::phase_type'(sonco_pkg::START_PHASE_RST) << (PB - 16);

   // only the low 32 product bits reach the phase (Q.32 step, wraps)
   assign freq_ext  = 32'(req.frequency);
   assign step_prod = freq_ext * step_ff;

   if (PB >= 32) begin : g_delta_wide
      assign phase_delta = sonco_pkg::phase_type'(step_prod) << (PB - 32);
   end else begin : g_delta_narrow
      assign phase_delta = step_prod[31 -: PB];
   end

   assign phase_in = phase_ff + phase_delta;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= phase_rst;
      end else if (csr_hit) begin
         phase_ff <= phase_load;
      end else if (req_take) begin
         phase_ff <= phase_in;
      end
   end

   // ---------------- quarter-wave table, registered read ----------------
   sonco_pkg::entry_type sine_rom [0:sonco_pkg::QSIZE];

   for (genvar k = 0; k <= sonco_pkg::QSIZE; k++) begin : g_rom
      assign sine_rom[k] = sonco_pkg::sine_entry(k);
   end

   logic [1:0]             quad;
   logic [AB-1:0]          tab_idx;
   sonco_pkg::rom_addr_type rom_addr;
   sonco_pkg::entry_type   rom_data_ff;
   logic                   neg_ff;

   assign quad     = phase_ff[PB-1 -: 2];
   assign tab_idx  = phase_ff[PB-3 -: AB];
   // odd quadrants run the table backwards
   assign rom_addr = quad[0] ?
                     (sonco_pkg::rom_addr_type'(sonco_pkg::QSIZE) - {1'b0, tab_idx}) :
                     {1'b0, tab_idx};

   always_ff @(posedge clock) begin
      if (s1_en) begin
         rom_data_ff <= sine_rom[rom_addr];
         neg_ff      <= quad[1];
      end
   end

   // ---------------- gain, round, saturate ----------------
   logic [MAG_W-1:0]      mag;
   logic [RND_W-1:0]      rounded;
   sonco_pkg::sample_type sample_in;
   sonco_pkg::sample_type sample_ff;

   assign mag     = MAG_W'(rom_data_ff) * MAG_W'(amp_ff);
   // half away from zero: round the magnitude, then apply the sign
   assign rounded = RND_W'(({1'b0, mag} + (MAG_W + 1)'(1 << (SB - 2))) >> (SB - 1));

   always_comb begin
      if (neg_ff) begin
         if (rounded > RND_W'(32768)) sample_in = 16'sh8000;
         else                         sample_in = sonco_pkg::sample_type'(-rounded[15:0]);
      end else begin
         if (rounded > RND_W'(32767)) sample_in = 16'sh7FFF;
         else                         sample_in = sonco_pkg::sample_type'(rounded[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp.valid  = out_vld_ff;
   assign rsp.sample = sample_ff;

   // ---------------- assertions ----------------
   a_csr_reload: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (phase_ff == (sonco_pkg::phase_type'(start_ff) << (PB - 16))))
      else $error("phase not reloaded after register write");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      (!(req.valid && req.ready) && !csr_wr_en) |=> $stable(phase_ff))
      else $error("phase moved without a request or write");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> s1_vld_ff)
      else $error("accepted word lost before table stage");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && out_vld_ff && !rsp.ready) |-> !req.ready)
      else $error("request taken while pipeline full and stalled");

endmodule
